>>> rtl/svlp_pkg.sv
package svlp_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CutoffW = 13;
  localparam int unsigned DampW   = 16;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned OpAW    = 17;
  localparam int unsigned OpBW    = 19;
  localparam int unsigned ProdW   = OpAW + OpBW;
  localparam int unsigned FShift  = 12;
  localparam int unsigned DShift  = 15;
  localparam int unsigned SumW    = ProdW - FShift + 1;

  localparam logic [CfgIdxW-1:0] CfgCutoff  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgDamping = 1'b1;

  localparam logic [CutoffW-1:0] CutoffRst = 13'd1024;
  localparam logic [DampW-1:0]   DampRst   = 16'd32768;

  localparam logic signed [SampleW-1:0] Limit = 16'sd32767;

  typedef enum logic [2:0] {
    StIdle,
    StMulLp,
    StLpMulD,
    StHp,
    StMulHp,
    StBp
  } svlp_state_e;

  typedef enum logic {
    OpACutoff,
    OpADamp
  } svlp_opa_e;

  typedef enum logic {
    OpBBand,
    OpBHigh
  } svlp_opb_e;

  typedef struct packed {
    logic      mul_en;
    svlp_opa_e sel_a;
    svlp_opb_e sel_b;
    logic      lp_en;
    logic      hp_en;
    logic      bp_en;
  } svlp_ctrl_t;

  function automatic logic signed [SampleW-1:0] clamp_sym(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    logic signed [SampleW-1:0] r;
    hi = SumW'(Limit);
    lo = -hi;
    if (v > hi) begin
      r = Limit;
    end else if (v < lo) begin
      r = -Limit;
    end else begin
      r = v[SampleW-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/svlp_if.sv
interface svlp_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [svlp_pkg::SampleW-1:0]    sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface svlp_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [svlp_pkg::SampleW-1:0]    sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

>>> rtl/svlp_mul.sv
module svlp_mul (
  input  logic                                  clk_i,
  input  svlp_pkg::svlp_ctrl_t                  ctrl_i,
  input  logic        [svlp_pkg::CutoffW-1:0]   cutoff_i,
  input  logic        [svlp_pkg::DampW-1:0]     damp_i,
  input  logic signed [svlp_pkg::SampleW-1:0]   band_i,
  input  logic signed [svlp_pkg::OpBW-1:0]      high_i,
  output logic signed [svlp_pkg::ProdW-1:0]     prod_o
);

  logic signed [svlp_pkg::OpAW-1:0]  op_a;
  logic signed [svlp_pkg::OpBW-1:0]  op_b;
  logic signed [svlp_pkg::ProdW-1:0] prod_d, prod_q;

  always_comb begin
    case (ctrl_i.sel_a)
      svlp_pkg::OpACutoff: op_a = $signed({{(svlp_pkg::OpAW - svlp_pkg::CutoffW){1'b0}},
                                           cutoff_i});
      svlp_pkg::OpADamp:   op_a = $signed({{(svlp_pkg::OpAW - svlp_pkg::DampW){1'b0}},
                                           damp_i});
      default:             op_a = '0;
    endcase
    case (ctrl_i.sel_b)
      svlp_pkg::OpBBand: op_b = svlp_pkg::OpBW'(band_i);
      svlp_pkg::OpBHigh: op_b = high_i;
      default:           op_b = '0;
    endcase
    prod_d = svlp_pkg::ProdW'(op_a) * svlp_pkg::ProdW'(op_b);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

>>> rtl/svlp_ctrl.sv
module svlp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_free_i,
  output logic                 in_ready_o,
  output svlp_pkg::svlp_ctrl_t ctrl_o
);

  svlp_pkg::svlp_state_e state_d, state_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      svlp_pkg::StIdle:   if (in_valid_i) state_d = svlp_pkg::StMulLp;
      svlp_pkg::StMulLp:  state_d = svlp_pkg::StLpMulD;
      svlp_pkg::StLpMulD: state_d = svlp_pkg::StHp;
      svlp_pkg::StHp:     state_d = svlp_pkg::StMulHp;
      svlp_pkg::StMulHp:  state_d = svlp_pkg::StBp;
      svlp_pkg::StBp:     if (out_free_i) state_d = svlp_pkg::StIdle;
      default:            state_d = svlp_pkg::StIdle;
    endcase
  end

  always_comb begin
    ctrl_o       = '0;
    ctrl_o.sel_a = svlp_pkg::OpACutoff;
    ctrl_o.sel_b = svlp_pkg::OpBBand;
    in_ready_o   = 1'b0;
    case (state_q)
      svlp_pkg::StIdle: begin
        in_ready_o = 1'b1;
      end
      svlp_pkg::StMulLp: begin
        ctrl_o.mul_en = 1'b1;
      end
      svlp_pkg::StLpMulD: begin
        ctrl_o.lp_en  = 1'b1;
        ctrl_o.mul_en = 1'b1;
        ctrl_o.sel_a  = svlp_pkg::OpADamp;
      end
      svlp_pkg::StHp: begin
        ctrl_o.hp_en = 1'b1;
      end
      svlp_pkg::StMulHp: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.sel_b  = svlp_pkg::OpBHigh;
      end
      svlp_pkg::StBp: begin
        ctrl_o.bp_en = out_free_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= svlp_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/state_variable_lowpass_filter.sv
// lowpass tap of a chamberlin state-variable filter, one sample per transaction
//
// channels: in_ch carries sample_in (signed 16 bit), out_ch carries sample_out,
// both valid/ready; cfg_we_i/cfg_idx_i/cfg_data_i write cutoff (index 0, q12, 13 bit) and damping
// (index 1, q15, 16 bit); the user must write only while the filter is idle, as the block does not check
//
// each sample takes three passes through one shared 17x19 multiplier under a
// six-state sequencer: f*bandpass, damping*bandpass, f*highpass
// the result goes into the output register in the bandpass state, with the bandpass update
// a new sample is taken only after the previous one is through the sequencer;
// in_ch.ready is high only while the sequencer is idle
//
// reset: both integrators clear to zero, cutoff returns to 1024 and damping
// to 32768, no result is pending
//
// receiver stall: the result sits in the output register; the next sample is
// still taken and worked up to the bandpass update, which waits until the
// output register is free
module state_variable_lowpass_filter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [svlp_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [svlp_pkg::CfgW-1:0]           cfg_data_i,
  svlp_in_if.sink                             in_ch,
  svlp_out_if.source                          out_ch
);

  logic        [svlp_pkg::CutoffW-1:0]  cutoff_q;
  logic        [svlp_pkg::DampW-1:0]    damp_q;
  logic signed [svlp_pkg::SampleW-1:0]  x_q;
  logic signed [svlp_pkg::SampleW-1:0]  lp_q, bp_q;
  logic signed [svlp_pkg::OpBW-1:0]     hp_d, hp_q;
  logic signed [svlp_pkg::ProdW-1:0]    prod;
  logic signed [svlp_pkg::SumW-1:0]     lp_sum, bp_sum;
  logic signed [svlp_pkg::SumW-1:0]     hp_wide;
  logic                                 out_valid_q;
  logic signed [svlp_pkg::SampleW-1:0]  out_q;
  logic                                 out_free;
  logic                                 in_ready;
  svlp_pkg::svlp_ctrl_t                 ctrl;

  assign out_free = !out_valid_q || out_ch.ready;

  svlp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .out_free_i (out_free),
    .in_ready_o (in_ready),
    .ctrl_o     (ctrl)
  );

  svlp_mul u_mul (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .cutoff_i (cutoff_q),
    .damp_i   (damp_q),
    .band_i   (bp_q),
    .high_i   (hp_q),
    .prod_o   (prod)
  );

  assign in_ch.ready = in_ready;

  always_comb begin
    lp_sum  = svlp_pkg::SumW'(lp_q)
            + svlp_pkg::SumW'($signed(prod[svlp_pkg::ProdW-1:svlp_pkg::FShift]));
    bp_sum  = svlp_pkg::SumW'(bp_q)
            + svlp_pkg::SumW'($signed(prod[svlp_pkg::ProdW-1:svlp_pkg::FShift]));
    hp_wide = svlp_pkg::SumW'(x_q) - svlp_pkg::SumW'(lp_q)
            - svlp_pkg::SumW'($signed(prod[svlp_pkg::ProdW-1:svlp_pkg::DShift]));
    hp_d    = hp_wide[svlp_pkg::OpBW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= svlp_pkg::CutoffRst;
      damp_q   <= svlp_pkg::DampRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        svlp_pkg::CfgCutoff:  cutoff_q <= cfg_data_i[svlp_pkg::CutoffW-1:0];
        svlp_pkg::CfgDamping: damp_q   <= cfg_data_i[svlp_pkg::DampW-1:0];
        default:              ;
      endcase
    end
  end

  // integrators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q <= '0;
      bp_q <= '0;
    end else begin
      if (ctrl.lp_en) lp_q <= svlp_pkg::clamp_sym(lp_sum);
      if (ctrl.bp_en) bp_q <= svlp_pkg::clamp_sym(bp_sum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ready) x_q <= in_ch.sample_in;
    if (ctrl.hp_en) hp_q <= hp_d;
    if (ctrl.bp_en) out_q <= lp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.bp_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.sample_out = out_q;

endmodule

>>> rtl/svlp_checker.sv
module svlp_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic signed [svlp_pkg::SampleW-1:0] sample_out_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(sample_out_i))
    else $error("result changed while stalled");

  a_out_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> sample_out_i != -svlp_pkg::SampleW'(32768))
    else $error("result outside clamp range");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while a sample is in work");

endmodule

bind state_variable_lowpass_filter svlp_checker u_svlp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_ch.valid),
  .in_ready_i   (in_ch.ready),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .sample_out_i (out_ch.sample_out)
);

>>> test/state_variable_lowpass_filter_tb.sv
`timescale 1ns / 100ps

module state_variable_lowpass_filter_tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                         cfg_we   = 1'b0;
  logic [svlp_pkg::CfgIdxW-1:0] cfg_idx  = svlp_pkg::CfgCutoff;
  logic [svlp_pkg::CfgW-1:0]    cfg_data = '0;

  logic                                src_valid  = 1'b0;
  logic signed [svlp_pkg::SampleW-1:0] src_sample = '0;
  logic                                sink_ready = 1'b0;

  svlp_in_if  in_ch ();
  svlp_out_if out_ch ();

  assign in_ch.valid     = src_valid;
  assign in_ch.sample_in = src_sample;
  assign out_ch.ready    = sink_ready;

  state_variable_lowpass_filter i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // filter copy: coefficients and both integrators
  logic [svlp_pkg::CutoffW-1:0]        cutoff_q12   = svlp_pkg::CutoffRst;
  logic [svlp_pkg::DampW-1:0]          damping_q15  = svlp_pkg::DampRst;
  logic signed [svlp_pkg::SampleW-1:0] lowpass_int  = '0;
  logic signed [svlp_pkg::SampleW-1:0] bandpass_int = '0;

  logic signed [svlp_pkg::SampleW-1:0] sample_queue[$];
  logic signed [svlp_pkg::SampleW-1:0] expected_lowpass[$];
  logic signed [svlp_pkg::SampleW-1:0] lowpass_want;

  int errors     = 0;
  bit calm       = 1'b0;
  int send_gap   = 0;
  int stall_left = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int pick_idle();
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic longint limit_audio(input longint v);
    if (v > 32767) begin
      return 32767;
    end else if (v < -32767) begin
      return -32767;
    end
    return v;
  endfunction

  // one filter step; >>> on signed longint floors, as the integrators need
  function automatic logic signed [svlp_pkg::SampleW-1:0] lowpass_next(
    input logic signed [svlp_pkg::SampleW-1:0] x
  );
    longint f;
    longint d;
    longint lp;
    longint bp;
    longint hp;
    f  = cutoff_q12;
    d  = damping_q15;
    lp = lowpass_int;
    bp = bandpass_int;
    lp = limit_audio(lp + ((f * bp) >>> svlp_pkg::FShift));
    hp = longint'(x) - lp - ((d * bp) >>> svlp_pkg::DShift);
    bp = limit_audio(bp + ((f * hp) >>> svlp_pkg::FShift));
    lowpass_int  = lp[svlp_pkg::SampleW-1:0];
    bandpass_int = bp[svlp_pkg::SampleW-1:0];
    return lp[svlp_pkg::SampleW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_valid  <= 1'b0;
      src_sample <= '0;
      send_gap   <= 0;
    end else begin
      if (src_valid && in_ch.ready) begin
        expected_lowpass.push_back(lowpass_next(src_sample));
      end
      if (!src_valid || in_ch.ready) begin
        if (send_gap > 0) begin
          src_valid <= 1'b0;
          send_gap  <= send_gap - 1;
        end else if (sample_queue.size() > 0) begin
          src_valid  <= 1'b1;
          src_sample <= sample_queue.pop_front();
          send_gap   <= pick_idle();
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sink_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_ch.valid && sink_ready) begin
        if (expected_lowpass.size() == 0) begin
          errors++;
          $display("%0t: result with no transaction pending: expected none, actual %0d",
                   $time, out_ch.sample_out);
        end else begin
          lowpass_want = expected_lowpass.pop_front();
          if (out_ch.sample_out !== lowpass_want) begin
            errors++;
            $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                     $time, lowpass_want, out_ch.sample_out);
          end
        end
      end
      if (stall_left > 0) begin
        sink_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        sink_ready <= 1'b1;
        stall_left <= pick_idle();
      end
    end
  end

  task automatic cfg_write(input logic [svlp_pkg::CfgIdxW-1:0] idx,
                           input logic [svlp_pkg::CfgW-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    if (idx == svlp_pkg::CfgCutoff) begin
      cutoff_q12 = data[svlp_pkg::CutoffW-1:0];
    end else begin
      damping_q15 = data[svlp_pkg::DampW-1:0];
    end
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // wait for the filter to go quiet with nothing outstanding
  task automatic drain();
    do begin
      @(negedge clk_i);
    end while (sample_queue.size() != 0 || src_valid || expected_lowpass.size() != 0);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic add_random(input int count);
    int left;
    int burst;
    int mode;
    logic signed [svlp_pkg::SampleW-1:0] level;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 20);
      if (burst > left) begin
        burst = left;
      end
      mode  = $urandom_range(0, 3);
      level = svlp_pkg::SampleW'($urandom);
      repeat (burst) begin
        case (mode)
          0: sample_queue.push_back(svlp_pkg::SampleW'($urandom));
          1: sample_queue.push_back(level);
          2: sample_queue.push_back(
               svlp_pkg::SampleW'(int'($urandom_range(0, 511)) - 256));
          default: begin
            case ($urandom_range(0, 2))
              0: sample_queue.push_back(16'sh7fff);
              1: sample_queue.push_back(16'sh8001);
              default: sample_queue.push_back(16'sh8000);
            endcase
          end
        endcase
      end
      left -= burst;
    end
  endtask

  initial begin
    int ph;
    logic [svlp_pkg::CfgW-1:0] val;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset coefficients
    @(negedge clk_i);
    sample_queue = '{16'sd0, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sd1, -16'sd1};
    drain();

    // widest cutoff, no damping: integrators run into the clamp
    cfg_write(svlp_pkg::CfgCutoff, svlp_pkg::CfgW'(8191));
    cfg_write(svlp_pkg::CfgDamping, svlp_pkg::CfgW'(0));
    @(negedge clk_i);
    sample_queue = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
                     16'sd0};
    drain();

    // cutoff zero freezes the state
    cfg_write(svlp_pkg::CfgCutoff, svlp_pkg::CfgW'(0));
    cfg_write(svlp_pkg::CfgDamping, svlp_pkg::CfgW'(65535));
    @(negedge clk_i);
    sample_queue = '{16'sd12345, 16'sh8000, 16'sd0};
    drain();

    cfg_write(svlp_pkg::CfgCutoff, svlp_pkg::CfgW'(4096));
    @(negedge clk_i);
    sample_queue = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000};
    drain();

    for (ph = 0; ph < 9; ph++) begin
      calm = (ph % 3 == 1);
      case ($urandom_range(0, 5))
        0: val = svlp_pkg::CfgW'(0);
        1: val = svlp_pkg::CfgW'(4096);
        2: val = svlp_pkg::CfgW'(8191);
        3: val = svlp_pkg::CfgW'($urandom_range(4097, 8190));
        default: val = svlp_pkg::CfgW'($urandom_range(1, 4095));
      endcase
      cfg_write(svlp_pkg::CfgCutoff, val);
      case ($urandom_range(0, 4))
        0: val = svlp_pkg::CfgW'(0);
        1: val = svlp_pkg::CfgW'(65535);
        2: val = svlp_pkg::CfgW'(32768);
        default: val = svlp_pkg::CfgW'($urandom);
      endcase
      cfg_write(svlp_pkg::CfgDamping, val);
      @(negedge clk_i);
      add_random(50);
      drain();
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
